// File: design/pcvtp_pkg.sv
package pcvtp_pkg;

  typedef struct packed {
    logic [12:0] note_cv;
    logic [10:0] volume;
  } pitch_item_t;

  typedef struct packed {
    logic [15:0] timer_top;
    logic [2:0]  prescale_select;
    logic [15:0] period_us;
    logic [9:0]  level_offset;
  } result_item_t;

  localparam logic [2:0] PS_DIV1    = 3'd0;
  localparam logic [2:0] PS_DIV8    = 3'd1;
  localparam logic [2:0] PS_DIV64   = 3'd2;
  localparam logic [2:0] PS_DIV256  = 3'd3;
  localparam logic [2:0] PS_DIV1024 = 3'd4;

  localparam logic [6:0]  OFFSET_RESET = 7'd45;
  localparam logic [12:0] CV_FULL      = 13'd4096;
  localparam logic [10:0] VOL_FULL     = 11'd1024;
  localparam logic [10:0] VOL_FLOOR    = 11'd20;
  localparam logic [17:0] OCT_BIAS     = 18'd73728;
  localparam logic [39:0] LN2_Q30      = 40'd744261118;
  localparam logic [30:0] ONE_Q30      = 31'd1073741824;
  localparam logic [45:0] PERIOD_SCALE = 46'd25000;
  localparam logic [40:0] DIV11_REC    = 41'd1525202;
  localparam logic [15:0] PERIOD_MIN   = 16'd956;
  localparam logic [15:0] PERIOD_MAX   = 16'd50000;

  function automatic logic [30:0] semi_q30(input logic [3:0] s);
    logic [30:0] v;
    case (s)
      4'd0:    v = 31'd1073741824;
      4'd1:    v = 31'd1137589835;
      4'd2:    v = 31'd1205234447;
      4'd3:    v = 31'd1276901417;
      4'd4:    v = 31'd1352829926;
      4'd5:    v = 31'd1433273380;
      4'd6:    v = 31'd1518500250;
      4'd7:    v = 31'd1608794974;
      4'd8:    v = 31'd1704458901;
      4'd9:    v = 31'd1805811301;
      4'd10:   v = 31'd1913190429;
      4'd11:   v = 31'd2026954652;
      default: v = 31'd0;
    endcase
    return v;
  endfunction

  // floor(a / 3) by reciprocal multiply
  function automatic logic [30:0] div3(input logic [31:0] a);
    logic [63:0] p;
    p = {32'd0, a} * 64'hAAAAAAAB;
    return p[63:33];
  endfunction

endpackage

// File: design/pitch_cv_to_timer_period.sv
// channel  valid         ready         payload
// pitch    pitch_valid   pitch_ready   pitch: note_cv, volume
// result   result_valid  result_ready  result: timer_top, prescale_select, period_us, level_offset
// config   cfg_valid     cfg_ready     cfg_data: semitone_offset
//
// 15-stage pipeline, one item per cycle while result_ready does not stall the output
// the stages carry the chain of series, mantissa and scaling multipliers
// reset clears all stage valid bits and sets semitone_offset to 45
// a stage holds only while it and every later stage are full and the result is not taken
// cfg_ready is always high
module pitch_cv_to_timer_period
  import pcvtp_pkg::*;
#(
  parameter int CLOCK_HZ    = 16000000,
  parameter int TIMER_RANGE = 65536
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         pitch_valid,
  output logic         pitch_ready,
  input  pitch_item_t  pitch,
  output logic         result_valid,
  input  logic         result_ready,
  output result_item_t result,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [6:0]   cfg_data
);

  localparam int NS = 15;
  localparam longint unsigned TIMER_DIV = 64'd2000000;
  localparam longint unsigned CLK_A = 64'(CLOCK_HZ) / TIMER_DIV;
  localparam longint unsigned CLK_B = 64'(CLOCK_HZ) % TIMER_DIV;
  localparam longint unsigned REC = (CLK_B * (64'd1 << 37) + TIMER_DIV - 64'd1) / TIMER_DIV;
  localparam longint unsigned REC_LO = REC % (64'd1 << 19);
  localparam longint unsigned REC_HI = REC >> 19;

  typedef enum logic [1:0] {
    PC_NORM,
    PC_LOW,
    PC_HIGH
  } pclass_t;

  typedef struct packed {
    logic [3:0] semi;
    logic [2:0] shift;
    pclass_t    cls;
    logic [9:0] lvl;
  } side_t;

  logic [6:0]  semitone_offset;
  logic [NS:1] v;
  logic [NS:1] adv;
  side_t       sd [1:14];

  logic [17:0] xo1;
  logic [9:0]  f2;
  logic [39:0] prod3;
  logic [25:0] y4, y5, y6;
  logic [21:0] y2_5, y2_6;
  logic [17:0] y3_6;
  logic [30:0] ser7;
  logic [30:0] m8;
  logic [45:0] t9;
  logic [19:0] w10;
  logic [16:0] q11;
  logic [15:0] per12, per13, per14;
  logic [21:0] pa13;
  logic [34:0] p1_13;
  logic [33:0] p2_13;
  logic [22:0] cyc14;

  // stall control
  always_comb begin
    logic allv;
    for (int i = 1; i <= NS; i++) begin
      allv = 1'b1;
      for (int j = i; j <= NS; j++) begin
        allv = allv & v[j];
      end
      adv[i] = !allv || result_ready;
    end
  end

  assign pitch_ready  = adv[1];
  assign result_valid = v[NS];
  assign cfg_ready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
      semitone_offset <= OFFSET_RESET;
    end else begin
      if (cfg_valid) begin
        semitone_offset <= cfg_data;
      end
      if (adv[1]) begin
        v[1] <= pitch_valid;
      end
      for (int i = 2; i <= NS; i++) begin
        if (adv[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // stage 1: clamp, bias, level offset
  logic [12:0] cv_c;
  logic [10:0] vol_c;
  logic [10:0] lvl_d;
  logic [17:0] cv15;
  logic [17:0] xo_next;
  side_t       sd1_next;

  always_comb begin
    cv_c    = (pitch.note_cv > CV_FULL) ? CV_FULL : pitch.note_cv;
    cv15    = ({5'd0, cv_c} << 4) - {5'd0, cv_c};
    xo_next = {1'b0, semitone_offset, 10'd0} + OCT_BIAS - cv15;
    vol_c   = (pitch.volume <= VOL_FLOOR) ? 11'd0 : pitch.volume;
    lvl_d   = (vol_c >= VOL_FULL) ? 11'd0 : (VOL_FULL - vol_c);
    sd1_next = '{semi: 4'd0, shift: 3'd0, cls: PC_NORM, lvl: lvl_d[10:1]};
  end

  // stage 2: octave split
  logic [11:0] oct_p;
  logic [4:0]  oct;
  logic [5:0]  oct3;
  logic [17:0] r_full;
  logic [4:0]  oct_sh;
  side_t       sd2_next;

  always_comb begin
    oct_p  = {6'd0, xo1[17:12]} * 12'd43;
    oct    = oct_p[11:7];
    oct3   = {1'b0, oct} + {oct, 1'b0};
    r_full = xo1 - {oct3, 12'd0};
    oct_sh = oct - 5'd4;
    sd2_next = sd[1];
    sd2_next.semi  = r_full[13:10];
    sd2_next.shift = oct_sh[2:0];
    if (oct <= 5'd3) begin
      sd2_next.cls = PC_LOW;
    end else if (oct >= 5'd11) begin
      sd2_next.cls = PC_HIGH;
    end else begin
      sd2_next.cls = PC_NORM;
    end
  end

  // datapath arithmetic
  logic [51:0] sq5;
  logic [47:0] cu6;
  logic [30:0] y3d;
  logic [61:0] mm8;
  logic [51:0] sh10;
  logic [40:0] qq11;
  logic [53:0] sum14;

  always_comb begin
    sq5   = 52'(y4) * 52'(y4);
    cu6   = 48'(y2_5) * 48'(y5);
    y3d   = div3(32'(y3_6[17:1]));
    mm8   = 62'(semi_q30(sd[7].semi)) * 62'(ser7);
    sh10  = {6'd0, t9} << sd[9].shift;
    qq11  = 41'(w10) * DIV11_REC;
    sum14 = (54'(p2_13) << 19) + 54'(p1_13);
  end

  logic [15:0] per12_next;

  always_comb begin
    case (sd[11].cls)
      PC_LOW:  per12_next = PERIOD_MIN;
      PC_HIGH: per12_next = PERIOD_MAX;
      PC_NORM: begin
        if (q11 < 17'(PERIOD_MIN)) begin
          per12_next = PERIOD_MIN;
        end else if (q11 > 17'(PERIOD_MAX)) begin
          per12_next = PERIOD_MAX;
        end else begin
          per12_next = q11[15:0];
        end
      end
      default: per12_next = PERIOD_MAX;
    endcase
  end

  // prescaler choice
  logic [23:0] c24;
  logic [23:0] tr24;
  logic [15:0] top_next;
  logic [2:0]  sel_next;

  always_comb begin
    c24      = {1'b0, cyc14};
    tr24     = 24'(TIMER_RANGE);
    sel_next = PS_DIV1024;
    top_next = 16'(TIMER_RANGE - 1);
    if (c24 < tr24) begin
      sel_next = PS_DIV1;
      top_next = c24[15:0];
    end else if ((c24 >> 3) < tr24) begin
      sel_next = PS_DIV8;
      top_next = c24[18:3];
    end else if ((c24 >> 6) < tr24) begin
      sel_next = PS_DIV64;
      top_next = c24[21:6];
    end else if ((c24 >> 8) < tr24) begin
      sel_next = PS_DIV256;
      top_next = c24[23:8];
    end else if ((c24 >> 10) < tr24) begin
      sel_next = PS_DIV1024;
      top_next = 16'(c24 >> 10);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      xo1   <= xo_next;
      sd[1] <= sd1_next;
    end
    if (adv[2]) begin
      f2    <= r_full[9:0];
      sd[2] <= sd2_next;
    end
    for (int i = 3; i <= 14; i++) begin
      if (adv[i]) begin
        sd[i] <= sd[i-1];
      end
    end
    if (adv[3]) begin
      prod3 <= 40'(f2) * LN2_Q30;
    end
    if (adv[4]) begin
      y4 <= 26'(div3(32'(prod3[39:12])));
    end
    if (adv[5]) begin
      y5   <= y4;
      y2_5 <= sq5[51:30];
    end
    if (adv[6]) begin
      y6   <= y5;
      y2_6 <= y2_5;
      y3_6 <= cu6[47:30];
    end
    if (adv[7]) begin
      ser7 <= ONE_Q30 + 31'(y6) + 31'(y2_6[21:1]) + y3d;
    end
    if (adv[8]) begin
      m8 <= mm8[60:30];
    end
    if (adv[9]) begin
      t9 <= 46'(m8) * PERIOD_SCALE;
    end
    if (adv[10]) begin
      w10 <= sh10[51:32];
    end
    if (adv[11]) begin
      q11 <= qq11[40:24];
    end
    if (adv[12]) begin
      per12 <= per12_next;
    end
    if (adv[13]) begin
      per13 <= per12;
      pa13  <= 22'(per12) * 22'(CLK_A);
      p1_13 <= 35'(per12) * 35'(REC_LO);
      p2_13 <= 34'(per12) * 34'(REC_HI);
    end
    if (adv[14]) begin
      per14 <= per13;
      cyc14 <= 23'(pa13) + 23'(sum14[53:37]);
    end
    if (adv[15]) begin
      result.timer_top       <= top_next;
      result.prescale_select <= sel_next;
      result.period_us       <= per14;
      result.level_offset    <= sd[14].lvl;
    end
  end

endmodule

// File: design/pcvtp_checker.sv
module pcvtp_checker
  import pcvtp_pkg::*;
(
  input logic         clk,
  input logic         rst,
  input logic         pitch_valid,
  input logic         pitch_ready,
  input logic         result_valid,
  input logic         result_ready,
  input result_item_t result
);

  // stalled result item holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result item changed while stalled");

  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

  a_period: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.period_us >= PERIOD_MIN && result.period_us <= PERIOD_MAX)
    else $error("period out of clamp range");

  a_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.prescale_select <= PS_DIV1024 && result.level_offset <= 10'd512)
    else $error("prescale or level offset out of range");

  // an open output slot never blocks the input
  a_flow: assert property (@(posedge clk) disable iff (rst)
    (!result_valid || result_ready) |-> pitch_ready)
    else $error("input blocked with room downstream");

endmodule

bind pitch_cv_to_timer_period pcvtp_checker u_pcvtp_checker (.*);

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import pcvtp_pkg::*;

  localparam int CLK_HZ         = 16000000;
  localparam int TIMER_SPAN     = 65536;
  localparam int HOLD_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT = 3000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         pitch_valid = 1'b0;
  logic         pitch_ready;
  pitch_item_t  pitch = '0;
  logic         result_valid;
  logic         result_ready = 1'b0;
  result_item_t result;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [6:0]   cfg_data = '0;

  pitch_item_t  notes_to_send[$];
  result_item_t settings_due[$];
  logic [6:0]   offset_shadow = OFFSET_RESET;
  logic         pitch_fired = 1'b0;
  logic         calm = 1'b0;
  logic         hold_arm = 1'b0;
  logic         hold_done = 1'b0;
  int           hold_left = 0;
  int           quiet_cycles = 0;
  int           mismatches = 0;
  int           items_taken = 0;
  int           results_checked = 0;
  int           input_stalls = 0;
  int           offsets_tried = 1;

  pitch_cv_to_timer_period #(
    .CLOCK_HZ   (CLK_HZ),
    .TIMER_RANGE(TIMER_SPAN)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .pitch_valid (pitch_valid),
    .pitch_ready (pitch_ready),
    .pitch       (pitch),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic logic [63:0] semitone_ratio(input logic [3:0] s);
    case (s)
      4'd0:    return 64'd1073741824;
      4'd1:    return 64'd1137589835;
      4'd2:    return 64'd1205234447;
      4'd3:    return 64'd1276901417;
      4'd4:    return 64'd1352829926;
      4'd5:    return 64'd1433273380;
      4'd6:    return 64'd1518500250;
      4'd7:    return 64'd1608794974;
      4'd8:    return 64'd1704458901;
      4'd9:    return 64'd1805811301;
      4'd10:   return 64'd1913190429;
      default: return 64'd2026954652;
    endcase
  endfunction

  // octave position split into octave, semitone and 1/1024 semitone, then turned into a clamped period
  function automatic logic [15:0] clamped_period(input logic [12:0] cv, input logic [6:0] ofs);
    logic [31:0] c, xo, oct, r;
    logic [63:0] y, y2, y3, series, m, v, p;
    c = (cv > 13'd4096) ? 32'd4096 : 32'(cv);
    xo = 32'(ofs) * 32'd1024 + 32'd73728 - c * 32'd15;
    oct = xo / 32'd12288;
    r = xo % 32'd12288;
    if (oct <= 32'd3) return 16'd956;
    if (oct >= 32'd11) return 16'd50000;
    y = (64'(r[9:0]) * 64'd744261118) / 64'd12288;
    y2 = (y * y) >> 30;
    y3 = (y2 * y) >> 30;
    series = (64'd1 << 30) + y + y2 / 64'd2 + y3 / 64'd6;
    m = (semitone_ratio(r[13:10]) * series) >> 30;
    v = (64'd25000 * m) << (oct - 32'd4);
    p = v / (64'd11 << 32);
    if (p < 64'd956) p = 64'd956;
    if (p > 64'd50000) p = 64'd50000;
    return p[15:0];
  endfunction

  function automatic result_item_t predict_timer_setting(input pitch_item_t it,
                                                         input logic [6:0] ofs);
    result_item_t res;
    logic [63:0]  cyc;
    logic [10:0]  vol;
    res.period_us = clamped_period(it.note_cv, ofs);
    cyc = (64'(CLK_HZ) * 64'(res.period_us)) / 64'd2000000;
    res.prescale_select = PS_DIV1;
    if (cyc >= 64'(TIMER_SPAN)) begin
      cyc = cyc >> 3;
      res.prescale_select = PS_DIV8;
    end
    if (cyc >= 64'(TIMER_SPAN)) begin
      cyc = cyc >> 3;
      res.prescale_select = PS_DIV64;
    end
    if (cyc >= 64'(TIMER_SPAN)) begin
      cyc = cyc >> 2;
      res.prescale_select = PS_DIV256;
    end
    if (cyc >= 64'(TIMER_SPAN)) begin
      cyc = cyc >> 2;
      res.prescale_select = PS_DIV1024;
    end
    if (cyc >= 64'(TIMER_SPAN)) cyc = 64'(TIMER_SPAN - 1);
    res.timer_top = cyc[15:0];
    vol = (it.volume <= 11'd20) ? 11'd0 : it.volume;
    res.level_offset = (vol >= 11'd1024) ? 10'd0 : 10'((11'd1024 - vol) >> 1);
    return res;
  endfunction

  function automatic pitch_item_t random_note();
    pitch_item_t it;
    it.note_cv = ($urandom_range(9) < 8) ? 13'($urandom_range(4096))
                                          : 13'($urandom_range(8191, 4097));
    case ($urandom_range(9))
      0:       it.volume = 11'($urandom_range(24, 16));
      1:       it.volume = 11'($urandom_range(2047, 1024));
      default: it.volume = 11'($urandom_range(1023));
    endcase
    return it;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic queue_note(input int cv, input int vol);
    pitch_item_t it;
    it.note_cv = 13'(cv);
    it.volume = 11'(vol);
    notes_to_send.push_back(it);
  endtask

  task automatic queue_random(input int n);
    repeat (n) notes_to_send.push_back(random_note());
  endtask

  task automatic drain();
    @(posedge clk);
    while (notes_to_send.size() != 0 || pitch_valid || settings_due.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_offset(input logic [6:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    offsets_tried++;
  endtask

  // sender
  always @(negedge clk) begin
    if (rst) begin
      pitch_valid <= 1'b0;
    end else if (!pitch_valid || pitch_fired) begin
      if (notes_to_send.size() != 0 && (calm || $urandom_range(99) >= 28)) begin
        pitch <= notes_to_send.pop_front();
        pitch_valid <= 1'b1;
      end else begin
        pitch_valid <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (hold_left != 0) begin
      result_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_arm && !hold_done) begin
      result_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      result_ready <= calm || ($urandom_range(99) >= 28);
    end
  end

  // predictor and result check
  always @(posedge clk) begin
    result_item_t want;
    pitch_fired = pitch_valid && pitch_ready && !rst;
    if (rst) begin
      offset_shadow = OFFSET_RESET;
    end else begin
      if (cfg_valid && cfg_ready) offset_shadow = cfg_data;
      if (pitch_fired) begin
        settings_due.push_back(predict_timer_setting(pitch, offset_shadow));
        items_taken++;
      end
      if (pitch_valid && !pitch_ready) input_stalls++;
      if (result_valid && result_ready) begin
        results_checked++;
        if (settings_due.size() == 0) begin
          report_mismatch("result item with no pending expectation");
        end else begin
          want = settings_due.pop_front();
          if (result.timer_top !== want.timer_top)
            report_mismatch($sformatf("timer_top got %0d exp %0d",
                                      result.timer_top, want.timer_top));
          if (result.prescale_select !== want.prescale_select)
            report_mismatch($sformatf("prescale_select got %0d exp %0d",
                                      result.prescale_select, want.prescale_select));
          if (result.period_us !== want.period_us)
            report_mismatch($sformatf("period_us got %0d exp %0d",
                                      result.period_us, want.period_us));
          if (result.level_offset !== want.level_offset)
            report_mismatch($sformatf("level_offset got %0d exp %0d",
                                      result.level_offset, want.level_offset));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (pitch_valid && pitch_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d cycles without progress", quiet_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // default offset: field extremes, saturation, volume threshold
    queue_note(0, 0);
    queue_note(4096, 1024);
    queue_note(4097, 1025);
    queue_note(8191, 2047);
    queue_note(2048, 20);
    queue_note(2048, 21);
    queue_note(1, 19);
    queue_note(4095, 1023);
    queue_note(1024, 512);
    queue_note(3072, 1);
    queue_note(2730, 1000);
    queue_note(500, 2046);
    queue_note(3500, 22);
    queue_note(100, 1024);
    queue_note(4000, 0);
    queue_note(8000, 30);
    queue_note(4096, 2047);
    queue_note(0, 2047);
    drain();

    // lowest offset drives the low period clamp
    write_offset(7'd0);
    queue_note(0, 0);
    queue_note(4096, 1024);
    queue_note(8191, 2047);
    queue_random(70);
    drain();

    // highest offset drives the high period clamp
    write_offset(7'd127);
    queue_note(0, 0);
    queue_note(4096, 1024);
    queue_note(8191, 2047);
    queue_random(70);
    drain();

    // receiver holds off long enough to back up the pipeline
    write_offset(7'($urandom_range(127)));
    hold_arm = 1'b1;
    queue_random(110);
    drain();

    // back-to-back traffic, no idling on either side
    write_offset(OFFSET_RESET);
    calm = 1'b1;
    queue_random(110);
    drain();
    calm = 1'b0;

    repeat (2) begin
      write_offset(7'($urandom_range(127)));
      queue_random(60);
      drain();
    end

    repeat (30) @(posedge clk);
    $display("%0d pitch items over %0d offset settings, %0d results checked",
             items_taken, offsets_tried, results_checked);
    $display("%0d input stall cycles seen, %0d field errors", input_stalls, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/pcvtp_pkg.sv
design/pitch_cv_to_timer_period.sv
design/pcvtp_checker.sv
verif/tb.sv
